/* rtl/parp_pkg.sv */
// ----------------------------------------------------------------------------
// parp_pkg
// Shared types and constants for the per-id action rate policer: field
// widths, command codes, register indexes, state and controller interface.
// ----------------------------------------------------------------------------
package parp_pkg;

  localparam int PROC_ID_W   = 15;
  localparam int CMD_W       = 3;
  localparam int LIMIT_W     = 16;
  localparam int TICK_W      = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 40;

  localparam int ID_SPACE_DEF   = 32768;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic                 KILL_EN_RST      = 1'b0;
  localparam logic [PROC_ID_W-1:0] OWN_ID_RST       = '0;
  localparam logic [LIMIT_W-1:0]   DEF_LIMIT_RST    = 16'd100;
  localparam logic [TICK_W-1:0]    FLUSH_PERIOD_RST = 32'd1000;
  localparam logic [LIMIT_W-1:0]   LIMIT_MAX        = 16'hFFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_REPORT  = 3'd0,
    CMD_TICK    = 3'd1,
    CMD_LEARN   = 3'd2,
    CMD_CLR_WL  = 3'd3,
    CMD_RST_LIM = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KILL_EN      = 2'd0,
    REG_OWN_ID       = 2'd1,
    REG_DEF_LIMIT    = 2'd2,
    REG_FLUSH_PERIOD = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    SW_ZERO   = 2'd0,
    SW_FLUSH  = 2'd1,
    SW_LEARN  = 2'd2,
    SW_CLR_WL = 2'd3
  } sweep_op_t;

  typedef enum logic [2:0] {
    ST_INIT       = 3'd0,
    ST_INIT_DRAIN = 3'd1,
    ST_IDLE       = 3'd2,
    ST_EXEC       = 3'd3,
    ST_SWEEP      = 3'd4,
    ST_DRAIN      = 3'd5,
    ST_FINISH     = 3'd6
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic sweep_start;
    logic sweep_rd;
    logic sweep_end;
    logic out_load;
    logic out_from_exec;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic flush_due;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/parp_ctrl.sv */
// ----------------------------------------------------------------------------
// parp_ctrl
// Sequencer of the policer: takes items, runs the count memory
// read-modify-write or a full-memory sweep, and hands results to the output.
// ----------------------------------------------------------------------------
module parp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  parp_pkg::sts_t  sts,
  output parp_pkg::ctl_t  ctl
);

  parp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= parp_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      parp_pkg::ST_INIT: begin
        ctl.sweep_rd = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = parp_pkg::ST_INIT_DRAIN;
        end
      end
      parp_pkg::ST_INIT_DRAIN: begin
        state_nxt = parp_pkg::ST_IDLE;
      end
      parp_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        ctl.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = parp_pkg::ST_EXEC;
        end
      end
      parp_pkg::ST_EXEC: begin
        ctl.exec = 1'b1;
        if (sts.cmd == parp_pkg::CMD_LEARN || sts.cmd == parp_pkg::CMD_CLR_WL ||
            (sts.cmd == parp_pkg::CMD_TICK && sts.flush_due)) begin
          ctl.sweep_start = 1'b1;
          state_nxt       = parp_pkg::ST_SWEEP;
        end else if (sts.out_free) begin
          ctl.out_load      = 1'b1;
          ctl.out_from_exec = 1'b1;
          state_nxt         = parp_pkg::ST_IDLE;
        end else begin
          state_nxt = parp_pkg::ST_FINISH;
        end
      end
      parp_pkg::ST_SWEEP: begin
        ctl.sweep_rd = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = parp_pkg::ST_DRAIN;
        end
      end
      parp_pkg::ST_DRAIN: begin
        ctl.sweep_end = 1'b1;
        state_nxt     = parp_pkg::ST_FINISH;
      end
      parp_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = parp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = parp_pkg::ST_INIT;
      end
    endcase
  end

endmodule

/* rtl/parp_dp.sv */
// ----------------------------------------------------------------------------
// parp_dp
// Datapath of the policer: configuration registers, the per-id memory of
// {count, trusted, killed}, sweep address pipeline, limit and tick registers
// and the output register.
// ----------------------------------------------------------------------------
module parp_dp #(
  parameter int ID_SPACE   = parp_pkg::ID_SPACE_DEF,
  parameter int COUNT_BITS = parp_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  parp_pkg::ctl_t                      ctl,
  output parp_pkg::sts_t                      sts,
  input  logic [parp_pkg::CMD_W-1:0]          in_cmd,
  input  logic [parp_pkg::PROC_ID_W-1:0]      in_proc_id,
  input  logic                                cfg_valid,
  input  logic [parp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [parp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [parp_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int SLOT_BITS = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
  localparam int WORD_W    = COUNT_BITS + 2;
  localparam int CMP_W     = (COUNT_BITS > parp_pkg::LIMIT_W) ? COUNT_BITS
                                                              : parp_pkg::LIMIT_W;
  localparam int PAD_W     = parp_pkg::OUT_TDATA_W - parp_pkg::LIMIT_W - 2
                             - parp_pkg::PROC_ID_W;

  // configuration
  logic                              kill_en_r;
  logic [parp_pkg::PROC_ID_W-1:0]    own_id_r;
  logic [parp_pkg::LIMIT_W-1:0]      def_limit_r;
  logic [parp_pkg::TICK_W-1:0]       flush_period_r;

  // item and state
  logic [parp_pkg::CMD_W-1:0]        cmd_r;
  logic [parp_pkg::PROC_ID_W-1:0]    pid_r;
  logic [SLOT_BITS-1:0]              slot_r;
  logic [SLOT_BITS-1:0]              slot_in;
  logic [parp_pkg::LIMIT_W-1:0]      limit_r, limit_nxt;
  logic [parp_pkg::TICK_W-1:0]       ticks_r, ticks_nxt, tick_inc;
  parp_pkg::cmd_t                    cmd_e;

  // memory and sweep
  logic [WORD_W-1:0]                 cnt_mem [ID_SPACE];
  logic [WORD_W-1:0]                 rd_data_r;
  logic [SLOT_BITS-1:0]              rd_addr;
  logic                              rd_en;
  logic                              mem_we;
  logic [SLOT_BITS-1:0]              wr_addr;
  logic [WORD_W-1:0]                 wr_data;
  logic [SLOT_BITS-1:0]              addr_r;
  logic [SLOT_BITS-1:0]              wb_addr_r;
  logic                              wb_valid_r;
  parp_pkg::sweep_op_t               op_r;
  logic [COUNT_BITS-1:0]             max_r, max_acc;
  logic [CMP_W-1:0]                  learn_top;
  logic [parp_pkg::LIMIT_W-1:0]      learn_lim;

  // report path
  logic [COUNT_BITS-1:0]             cnt, cnt_inc;
  logic                              trusted, killed;
  logic                              rpt_do, kill_c, flush_c;
  logic [parp_pkg::PROC_ID_W-1:0]    kill_id_c;

  // result holding and output register
  logic                              res_kill_r, res_flush_r;
  logic [parp_pkg::PROC_ID_W-1:0]    res_id_r;
  logic                              out_valid_r;
  logic                              out_kill_r, out_flush_r;
  logic [parp_pkg::PROC_ID_W-1:0]    out_id_r;
  logic [parp_pkg::LIMIT_W-1:0]      out_limit_r;

  // store index: the id taken modulo the id space
  if (ID_SPACE >= (2 ** parp_pkg::PROC_ID_W)) begin : g_slot_wide
    assign slot_in = SLOT_BITS'(in_proc_id);
  end else if ((ID_SPACE & (ID_SPACE - 1)) == 0) begin : g_slot_pow2
    assign slot_in = in_proc_id[SLOT_BITS-1:0];
  end else begin : g_slot_recip
    localparam int K  = parp_pkg::PROC_ID_W + SLOT_BITS;
    localparam int MW = parp_pkg::PROC_ID_W + 2;
    localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << K) + 64'(ID_SPACE) - 64'd1) / 64'(ID_SPACE));
    logic [parp_pkg::PROC_ID_W+MW-1:0] prod;
    logic [parp_pkg::PROC_ID_W-1:0]    quo;
    logic [parp_pkg::PROC_ID_W-1:0]    back;
    logic [parp_pkg::PROC_ID_W-1:0]    rem;
    // exact floor quotient for every 15-bit id, so no correction step
    assign prod    = in_proc_id * RECIP;
    assign quo     = parp_pkg::PROC_ID_W'(prod >> K);
    assign back    = parp_pkg::PROC_ID_W'(quo * parp_pkg::PROC_ID_W'(ID_SPACE));
    assign rem     = in_proc_id - back;
    assign slot_in = rem[SLOT_BITS-1:0];
  end

  assign cmd_e = parp_pkg::cmd_t'(cmd_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kill_en_r      <= parp_pkg::KILL_EN_RST;
      own_id_r       <= parp_pkg::OWN_ID_RST;
      def_limit_r    <= parp_pkg::DEF_LIMIT_RST;
      flush_period_r <= parp_pkg::FLUSH_PERIOD_RST;
    end else if (cfg_valid) begin
      unique case (parp_pkg::reg_idx_t'(cfg_index))
        parp_pkg::REG_KILL_EN:      kill_en_r      <= cfg_data[0];
        parp_pkg::REG_OWN_ID:       own_id_r       <= cfg_data[parp_pkg::PROC_ID_W-1:0];
        parp_pkg::REG_DEF_LIMIT:    def_limit_r    <= cfg_data[parp_pkg::LIMIT_W-1:0];
        parp_pkg::REG_FLUSH_PERIOD: flush_period_r <= cfg_data[parp_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // read-modify-write of one entry
  always_comb begin
    cnt       = rd_data_r[WORD_W-1:2];
    trusted   = rd_data_r[1];
    killed    = rd_data_r[0];
    cnt_inc   = (&cnt) ? cnt : cnt + 1'b1;
    rpt_do    = ctl.exec && (cmd_e == parp_pkg::CMD_REPORT) && (pid_r != own_id_r);
    kill_c    = rpt_do && kill_en_r && (CMP_W'(cnt_inc) > CMP_W'(limit_r)) &&
                !trusted && !killed;
    kill_id_c = kill_c ? pid_r : '0;
    tick_inc  = (&ticks_r) ? ticks_r : ticks_r + 1'b1;
    flush_c   = (cmd_e == parp_pkg::CMD_TICK) && (tick_inc > flush_period_r);
  end

  // learn: running maximum over the sweep write-back stream
  always_comb begin
    max_acc = max_r;
    if (wb_valid_r && op_r == parp_pkg::SW_LEARN && cnt > max_r) begin
      max_acc = cnt;
    end
    learn_top = (CMP_W'(max_acc) > CMP_W'(def_limit_r)) ? CMP_W'(max_acc)
                                                        : CMP_W'(def_limit_r);
    learn_lim = (learn_top > CMP_W'(parp_pkg::LIMIT_MAX)) ? parp_pkg::LIMIT_MAX
                                                          : learn_top[parp_pkg::LIMIT_W-1:0];
  end

  // memory ports
  always_comb begin
    rd_en   = ctl.accept || ctl.sweep_rd;
    rd_addr = ctl.accept ? slot_in : addr_r;
    mem_we  = wb_valid_r || rpt_do;
    wr_addr = wb_valid_r ? wb_addr_r : slot_r;
    wr_data = {cnt_inc, trusted, killed | kill_c};
    if (wb_valid_r) begin
      case (op_r)
        parp_pkg::SW_ZERO:   wr_data = '0;
        parp_pkg::SW_FLUSH:  wr_data = {{COUNT_BITS{1'b0}}, trusted, 1'b0};
        parp_pkg::SW_LEARN:  wr_data = {{COUNT_BITS{1'b0}}, (cnt != '0), killed};
        parp_pkg::SW_CLR_WL: wr_data = {cnt, 1'b0, killed};
        default:             wr_data = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= cnt_mem[rd_addr];
    end
  end

  // sweep address and write-back pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r     <= '0;
      wb_valid_r <= 1'b0;
      op_r       <= parp_pkg::SW_ZERO;
    end else begin
      wb_valid_r <= ctl.sweep_rd;
      if (ctl.sweep_start) begin
        addr_r <= '0;
        case (cmd_e)
          parp_pkg::CMD_LEARN:  op_r <= parp_pkg::SW_LEARN;
          parp_pkg::CMD_CLR_WL: op_r <= parp_pkg::SW_CLR_WL;
          default:              op_r <= parp_pkg::SW_FLUSH;
        endcase
      end else if (ctl.sweep_rd) begin
        addr_r <= sts.sweep_last ? '0 : addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= addr_r;
    max_r     <= ctl.sweep_start ? '0 : max_acc;
    if (ctl.accept) begin
      cmd_r  <= in_cmd;
      pid_r  <= in_proc_id;
      slot_r <= slot_in;
    end
    if (ctl.exec) begin
      res_kill_r  <= kill_c;
      res_id_r    <= kill_id_c;
      res_flush_r <= flush_c;
    end
  end

  // limit and elapsed ticks
  always_comb begin
    limit_nxt = limit_r;
    ticks_nxt = ticks_r;
    if (ctl.exec && cmd_e == parp_pkg::CMD_RST_LIM) begin
      limit_nxt = def_limit_r;
    end
    if (ctl.exec && cmd_e == parp_pkg::CMD_TICK) begin
      ticks_nxt = flush_c ? '0 : tick_inc;
    end
    if (ctl.sweep_end && op_r == parp_pkg::SW_LEARN) begin
      limit_nxt = learn_lim;
      ticks_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= parp_pkg::DEF_LIMIT_RST;
      ticks_r <= '0;
    end else begin
      limit_r <= limit_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_kill_r  <= ctl.out_from_exec ? kill_c    : res_kill_r;
      out_id_r    <= ctl.out_from_exec ? kill_id_c : res_id_r;
      out_flush_r <= ctl.out_from_exec ? flush_c   : res_flush_r;
      out_limit_r <= limit_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_limit_r, out_flush_r, out_id_r, out_kill_r};

  assign sts.cmd        = cmd_e;
  assign sts.flush_due  = flush_c;
  assign sts.sweep_last = (addr_r == SLOT_BITS'(ID_SPACE - 1));
  assign sts.out_free   = !out_valid_r || out_tready;

endmodule

/* rtl/per_id_action_rate_policer.sv */
// ----------------------------------------------------------------------------
// per_id_action_rate_policer
// Counts actions per process id, keeps a trusted list and a killed set, and
// issues one kill order when an untrusted id goes over the current limit.
// ----------------------------------------------------------------------------
// Every input transfer gives exactly one result transfer. Report, tick without
// flush, reset-threshold and unknown commands read the id's entry of the count
// memory when the item is taken; a report then writes the updated entry back.
// Learn, clear whitelist and a tick that flushes sweep the whole count memory
// one entry a cycle through its single read and write port.
// After reset a clearing pass over the whole count memory runs before in_tready
// rises; the configuration port is always ready. A result waiting on
// out_tready sits in the output register and does not hold off the next input
// transfer; that item then waits for out_tready before it finishes, and the
// input stays closed until it does.
module per_id_action_rate_policer #(
  parameter int ID_SPACE   = parp_pkg::ID_SPACE_DEF,
  parameter int COUNT_BITS = parp_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [parp_pkg::IN_TDATA_W-1:0]   in_tdata,   // [14:0] proc_id
  input  logic [parp_pkg::IN_TUSER_W-1:0]   in_tuser,   // [2:0] cmd
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] kill_valid, [15:1] kill_id, [16] flushed, [32:17] current_limit
  output logic [parp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [parp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [parp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  parp_pkg::ctl_t ctl;
  parp_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  parp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  parp_dp #(
    .ID_SPACE   (ID_SPACE),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_cmd     (in_tuser[parp_pkg::CMD_W-1:0]),
    .in_proc_id (in_tdata[parp_pkg::PROC_ID_W-1:0]),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* bench/parp_checker.sv */
// ----------------------------------------------------------------------------
// parp_checker
// Watches the config, command and verdict streams of the action rate policer.
// It keeps its own copy of the per-id counts, trusted and killed sets, limit and
// tick counter. It works out the verdict of every accepted command and compares
// each verdict transfer, field by field, with the oldest verdict still owed.
// ----------------------------------------------------------------------------
module parp_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [parp_pkg::IN_TDATA_W-1:0]  in_tdata,   // [14:0] proc_id
  input  logic [parp_pkg::IN_TUSER_W-1:0]  in_tuser,   // [2:0] cmd
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] kill_valid, [15:1] kill_id, [16] flushed, [32:17] current_limit
  input  logic [parp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [parp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [parp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               mismatches,
  output int                               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                           kill_v;
    logic [parp_pkg::PROC_ID_W-1:0] kill_id;
    logic                           flushed;
    logic [parp_pkg::LIMIT_W-1:0]   limit;
  } verdict_t;

  bit [parp_pkg::COUNT_BITS_DEF-1:0] act_cnt [parp_pkg::ID_SPACE_DEF];
  bit                                trusted [parp_pkg::ID_SPACE_DEF];
  bit                                killed  [parp_pkg::ID_SPACE_DEF];
  bit [parp_pkg::LIMIT_W-1:0]        cur_limit;
  bit [parp_pkg::TICK_W-1:0]         ticks;

  bit                                kill_en;
  bit [parp_pkg::PROC_ID_W-1:0]      own_id;
  bit [parp_pkg::LIMIT_W-1:0]        def_limit;
  bit [parp_pkg::TICK_W-1:0]         flush_period;

  verdict_t owed_verdicts [$];
  int       errors = 0;
  int       n_owed = 0;

  assign mismatches  = errors;
  assign outstanding = n_owed;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic verdict_t apply_command(input logic [parp_pkg::CMD_W-1:0] op,
                                             input logic [parp_pkg::PROC_ID_W-1:0] pid);
    verdict_t                   v;
    bit [parp_pkg::LIMIT_W-1:0] best;
    v = '0;
    case (op)
      parp_pkg::CMD_REPORT: begin
        if (pid != own_id) begin
          if (act_cnt[pid] != '1) act_cnt[pid]++;
          if (kill_en && act_cnt[pid] > cur_limit && !trusted[pid] && !killed[pid]) begin
            killed[pid] = 1'b1;
            v.kill_v    = 1'b1;
            v.kill_id   = pid;
          end
        end
      end
      parp_pkg::CMD_TICK: begin
        if (ticks != '1) ticks++;
        if (ticks > flush_period) begin
          for (int i = 0; i < parp_pkg::ID_SPACE_DEF; i++) begin
            act_cnt[i] = '0;
            killed[i]  = 1'b0;
          end
          ticks     = '0;
          v.flushed = 1'b1;
        end
      end
      parp_pkg::CMD_LEARN: begin
        // trust every id with a nonzero count, limit follows the busiest one but not below the default
        best = def_limit;
        for (int i = 0; i < parp_pkg::ID_SPACE_DEF; i++) begin
          trusted[i] = (act_cnt[i] != 0);
          if (act_cnt[i] > best) best = act_cnt[i];
          act_cnt[i] = '0;
        end
        cur_limit = best;
        ticks     = '0;
      end
      parp_pkg::CMD_CLR_WL: begin
        for (int i = 0; i < parp_pkg::ID_SPACE_DEF; i++) trusted[i] = 1'b0;
      end
      parp_pkg::CMD_RST_LIM: cur_limit = def_limit;
      default: ;
    endcase
    v.limit = cur_limit;
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    verdict_t seen;
    if (!rst_n) begin
      kill_en      = parp_pkg::KILL_EN_RST;
      own_id       = parp_pkg::OWN_ID_RST;
      def_limit    = parp_pkg::DEF_LIMIT_RST;
      flush_period = parp_pkg::FLUSH_PERIOD_RST;
      cur_limit    = parp_pkg::DEF_LIMIT_RST;
      ticks        = '0;
      for (int i = 0; i < parp_pkg::ID_SPACE_DEF; i++) begin
        act_cnt[i] = '0;
        trusted[i] = 1'b0;
        killed[i]  = 1'b0;
      end
      owed_verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          parp_pkg::REG_KILL_EN:      kill_en      = cfg_data[0];
          parp_pkg::REG_OWN_ID:       own_id       = cfg_data[parp_pkg::PROC_ID_W-1:0];
          parp_pkg::REG_DEF_LIMIT:    def_limit    = cfg_data[parp_pkg::LIMIT_W-1:0];
          parp_pkg::REG_FLUSH_PERIOD: flush_period = cfg_data[parp_pkg::TICK_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        owed_verdicts.push_back(apply_command(in_tuser[parp_pkg::CMD_W-1:0],
                                              in_tdata[parp_pkg::PROC_ID_W-1:0]));
      if (out_tvalid && out_tready) begin
        seen.kill_v  = out_tdata[0];
        seen.kill_id = out_tdata[15:1];
        seen.flushed = out_tdata[16];
        seen.limit   = out_tdata[32:17];
        if (owed_verdicts.size() == 0) begin
          flag_mismatch($sformatf("verdict transfer with none owed: %h", out_tdata));
        end else begin
          want = owed_verdicts.pop_front();
          if (seen.kill_v !== want.kill_v)
            flag_mismatch($sformatf("kill_valid %b, want %b", seen.kill_v, want.kill_v));
          if (seen.kill_id !== want.kill_id)
            flag_mismatch($sformatf("kill_id %h, want %h", seen.kill_id, want.kill_id));
          if (seen.flushed !== want.flushed)
            flag_mismatch($sformatf("flushed %b, want %b", seen.flushed, want.flushed));
          if (seen.limit !== want.limit)
            flag_mismatch($sformatf("current_limit %0d, want %0d", seen.limit, want.limit));
        end
      end
    end
    n_owed <= owed_verdicts.size();
  end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the per-id action rate policer. A directed run
// covers reset settings, own id, kill once, flush, learn, whitelist clear,
// threshold restore and unknown commands; random phases follow with
// different settings and with sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [parp_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;   // [14:0] proc_id
  logic [parp_pkg::IN_TUSER_W-1:0]  in_tuser   = '0;   // [2:0] cmd
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // [0] kill_valid, [15:1] kill_id, [16] flushed, [32:17] current_limit
  logic [parp_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [parp_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [parp_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  always #1 clk = ~clk;

  per_id_action_rate_policer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  parp_checker police_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  task automatic send_item(input logic [parp_pkg::CMD_W-1:0]     op,
                           input logic [parp_pkg::PROC_ID_W-1:0] pid);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, pid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // wait until every verdict owed has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input parp_pkg::reg_idx_t              idx,
                           input logic [parp_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic                           ke,
                           input logic [parp_pkg::PROC_ID_W-1:0] me,
                           input logic [parp_pkg::LIMIT_W-1:0]   lim,
                           input logic [parp_pkg::TICK_W-1:0]    period);
    write_reg(parp_pkg::REG_KILL_EN, parp_pkg::CFG_DATA_W'(ke));
    write_reg(parp_pkg::REG_OWN_ID, parp_pkg::CFG_DATA_W'(me));
    write_reg(parp_pkg::REG_DEF_LIMIT, parp_pkg::CFG_DATA_W'(lim));
    write_reg(parp_pkg::REG_FLUSH_PERIOD, period);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int n_items, input int idle_in, input int stall_out,
                            input logic [parp_pkg::TICK_W-1:0] period);
    logic [parp_pkg::PROC_ID_W-1:0] pool [6];
    logic [parp_pkg::PROC_ID_W-1:0] me;
    logic [parp_pkg::PROC_ID_W-1:0] pid;
    int                             roll;
    int                             done_items;
    me = parp_pkg::PROC_ID_W'($urandom_range(0, 32767));
    foreach (pool[k]) pool[k] = parp_pkg::PROC_ID_W'($urandom_range(0, 32767));
    // the block's own id shows up among the busy ids
    pool[0] = me;
    configure($urandom_range(0, 9) != 0, me,
              parp_pkg::LIMIT_W'($urandom_range(0, 6)), period);
    send_idle_pct = idle_in;
    stall_pct     = stall_out;
    done_items    = 0;
    while (done_items < n_items) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) pid = parp_pkg::PROC_ID_W'($urandom_range(0, 32767));
      else pid = pool[$urandom_range(0, 5)];
      if (roll < 84) send_item(parp_pkg::CMD_REPORT, pid);
      else if (roll < 91) send_item(parp_pkg::CMD_TICK, pid);
      else if (roll < 94) send_item(parp_pkg::CMD_RST_LIM, pid);
      else if (roll < 97) send_item(parp_pkg::CMD_W'($urandom_range(5, 7)), pid);
      else if (roll < 98) send_item(parp_pkg::CMD_LEARN, pid);
      else send_item(parp_pkg::CMD_CLR_WL, pid);
      done_items++;
    end
    drain();
  endtask

  initial begin
    #200_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    // reset settings: kills off, own id zero, no flush yet
    send_item(parp_pkg::CMD_REPORT, 15'h0001);
    send_item(parp_pkg::CMD_TICK, 15'h0000);
    drain();

    // kill once, own id never counted, every tick flushes
    configure(1'b1, 15'h7FFF, 16'd1, 32'd0);
    send_item(parp_pkg::CMD_REPORT, 15'h0000);
    send_item(parp_pkg::CMD_REPORT, 15'h0000);
    send_item(parp_pkg::CMD_REPORT, 15'h0000);
    send_item(parp_pkg::CMD_REPORT, 15'h7FFF);
    send_item(parp_pkg::CMD_REPORT, 15'h7FFF);
    send_item(parp_pkg::CMD_REPORT, 15'h2AAA);
    send_item(parp_pkg::CMD_REPORT, 15'h2AAA);
    send_item(parp_pkg::CMD_REPORT, 15'h5555);
    send_item(parp_pkg::CMD_TICK, 15'h5555);
    send_item(parp_pkg::CMD_REPORT, 15'h0000);
    send_item(parp_pkg::CMD_REPORT, 15'h0000);
    repeat (3) send_item(parp_pkg::CMD_REPORT, 15'h1234);
    send_item(parp_pkg::CMD_LEARN, 15'h0000);
    send_item(parp_pkg::CMD_RST_LIM, 15'h0000);
    // trusted id stays alive, the untrusted one is killed
    send_item(parp_pkg::CMD_REPORT, 15'h1234);
    send_item(parp_pkg::CMD_REPORT, 15'h1234);
    send_item(parp_pkg::CMD_REPORT, 15'h5555);
    send_item(parp_pkg::CMD_REPORT, 15'h5555);
    send_item(parp_pkg::CMD_CLR_WL, 15'h0000);
    send_item(parp_pkg::CMD_REPORT, 15'h1234);
    send_item(parp_pkg::CMD_W'(5), 15'h7FFF);
    send_item(parp_pkg::CMD_W'(6), 15'h7FFF);
    send_item(parp_pkg::CMD_W'(7), 15'h7FFF);
    drain();

    // kills off, largest threshold, flush never due
    configure(1'b0, 15'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(parp_pkg::CMD_TICK, 15'h0000);
    send_item(parp_pkg::CMD_TICK, 15'h0000);
    send_item(parp_pkg::CMD_REPORT, 15'h0000);
    send_item(parp_pkg::CMD_REPORT, 15'h7FFF);
    send_item(parp_pkg::CMD_REPORT, 15'h7FFF);
    send_item(parp_pkg::CMD_RST_LIM, 15'h0000);
    send_item(parp_pkg::CMD_LEARN, 15'h0000);
    drain();

    run_random(90, 0, 0, 32'd2);
    run_random(90, 87, 0, 32'hFFFF_FFFF);
    run_random(90, 0, 87, parp_pkg::TICK_W'($urandom_range(1, 8)));
    run_random(90, 21, 21, 32'd5);

    repeat (50) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/parp_pkg.sv
rtl/parp_ctrl.sv
rtl/parp_dp.sv
rtl/per_id_action_rate_policer.sv
bench/parp_checker.sv
bench/tb_top.sv
